[sv/dmlr_pkg.sv]
// Shared constants, types and state encoding for the downmix linear resampler.
// Used by every module of the block; depends on nothing else.

package dmlr_pkg;

   // Default for the largest channel count the frame accumulator is sized for.
   parameter int unsigned MAX_CHANNELS_DEF = 8;

   // Fixed payload widths.
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned CNT_REG_W  = 4;
   localparam int unsigned STEP_W     = 24;
   localparam int unsigned PHASE_W    = STEP_W + 1;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 24;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Q16      = 1'b1;

   // Register reset values.
   localparam logic [CNT_REG_W-1:0] CHANNEL_COUNT_RESET = 4'd1;
   localparam logic [STEP_W-1:0]    STEP_RESET          = 24'd65536;

   // Phase arithmetic: one source frame is 1.0; steps are Q8.16 and the phase Q9.16.
   localparam logic [STEP_W-1:0]  MIN_STEP  = 24'd16384;
   localparam logic [PHASE_W-1:0] PHASE_ONE = 25'h0010000;

   // At most four results per frame; the counter holds results already sent.
   localparam int unsigned RUN_CNT_W = 2;
   localparam logic [RUN_CNT_W-1:0] RUN_FINAL = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_OUT
   } dmlr_state_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic mul_issue;
      logic emit;
   } dmlr_ctrl_type;

endpackage

[sv/downmix_linear_resampler_core.sv]
// Downmix linear resampler: interleaved PCM in, mono out.
// Depends on dmlr_pkg, dmlr_avg_div and dmlr_interp.

// Each input beat carries one channel sample. A beat that does not close a frame is
// taken while the block stays idle and ready for the next beat. A beat that closes a
// frame holds req_stall high while the frame is averaged and interpolated: the beat
// is accepted, the bit-serial averaging divider steps once per bit of the frame sum
// and then flags completion, and each result passes through a multiply state and an
// output state; stalls on the result side hold the output state. One result beat
// waits in the output register while the block goes on to accept the next input.
// There is no clearing pass after reset. Configuration writes are always taken
// (csr_ready is tied high) and must only be made while the block is idle. The first
// frame of a stream is only stored; results begin with the second frame.

module downmix_linear_resampler_core #(
   parameter int unsigned MAX_CHANNELS = dmlr_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [dmlr_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic                                   req_stream_start,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [dmlr_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic                                   rsp_last_in_run,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [dmlr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [dmlr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned SUM_W = dmlr_pkg::SAMPLE_W + $clog2(MAX_CHANNELS);
   localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // Configuration registers.
   logic [dmlr_pkg::CNT_REG_W-1:0] chan_count_ff, chan_count_in;
   logic [dmlr_pkg::STEP_W-1:0]    step_ff, step_in;

   // Stream state.
   dmlr_pkg::dmlr_state_type       state_ff, state_in;
   logic [IDX_W-1:0]               chan_idx_ff, chan_idx_in;
   logic signed [SUM_W-1:0]        chan_sum_ff, chan_sum_in;
   logic signed [dmlr_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [dmlr_pkg::SAMPLE_W-1:0] cur_ff, cur_in;
   logic                           have_prev_ff, have_prev_in;
   logic [dmlr_pkg::PHASE_W-1:0]   pos_ff, pos_in;
   logic [dmlr_pkg::RUN_CNT_W-1:0] run_cnt_ff, run_cnt_in;

   // Output register.
   logic                           out_valid_ff, out_valid_in;
   logic signed [dmlr_pkg::SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                           out_last_ff, out_last_in;

   dmlr_pkg::dmlr_ctrl_type        ctrl;

   logic [CNT_W-1:0]               n_eff;
   logic [dmlr_pkg::STEP_W-1:0]    step_eff;
   logic signed [SUM_W-1:0]        base_sum;
   logic [IDX_W-1:0]               base_idx;
   logic signed [SUM_W-1:0]        new_sum;
   logic [CNT_W-1:0]               idx_inc;
   logic                           frame_done;
   logic                           out_free;
   logic                           pos_in_frame;
   logic [dmlr_pkg::PHASE_W-1:0]   pos_next;
   logic                           run_last;
   logic [dmlr_pkg::PHASE_W-1:0]   wrap_src;
   logic [dmlr_pkg::PHASE_W-1:0]   wrap_diff;
   logic [dmlr_pkg::PHASE_W-1:0]   pos_wrapped;

   logic                           div_done;
   logic signed [dmlr_pkg::SAMPLE_W-1:0] div_mono;
   logic signed [dmlr_pkg::SAMPLE_W-1:0] interp_out;

   // ---------------------------------------------------------------------------------
   // Configuration port. Writes are always taken, but must only be made while idle.
   // ---------------------------------------------------------------------------------
   always_comb begin
      chan_count_in = chan_count_ff;
      step_in       = step_ff;
      if (csr_valid) begin
         case (csr_index)
            dmlr_pkg::CSR_CHANNEL_COUNT: chan_count_in = csr_wdata[dmlr_pkg::CNT_REG_W-1:0];
            dmlr_pkg::CSR_STEP_Q16:      step_in       = csr_wdata;
            default:                     ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // A zero channel count behaves as mono; counts above the accumulator's size are
   // clamped. Steps below a quarter are raised, which bounds a frame to four results.
   always_comb begin
      if (chan_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(chan_count_ff) > MAX_CHANNELS) begin
         n_eff = CNT_W'(MAX_CHANNELS);
      end else begin
         n_eff = CNT_W'(chan_count_ff);
      end
      step_eff = (step_ff < dmlr_pkg::MIN_STEP) ? dmlr_pkg::MIN_STEP : step_ff;
   end

   // ---------------------------------------------------------------------------------
   // Frame accumulation and phase arithmetic.
   // ---------------------------------------------------------------------------------
   always_comb begin
      base_sum   = req_stream_start ? '0 : chan_sum_ff;
      base_idx   = req_stream_start ? '0 : chan_idx_ff;
      new_sum    = base_sum + SUM_W'(req_sample_in);
      idx_inc    = CNT_W'(base_idx) + CNT_W'(1);
      // Lowering the count mid-frame closes the frame as soon as the index reaches it.
      frame_done = idx_inc >= n_eff;

      out_free     = !out_valid_ff || !rsp_stall;
      pos_in_frame = pos_ff < dmlr_pkg::PHASE_ONE;
      pos_next     = pos_ff + {1'b0, step_eff};
      run_last     = (pos_next >= dmlr_pkg::PHASE_ONE) || (run_cnt_ff == dmlr_pkg::RUN_FINAL);

      // The phase moves on by one source frame whenever a frame other than a stream's first is finished with.
      wrap_src    = (state_ff == dmlr_pkg::ST_OUT) ? pos_next : pos_ff;
      wrap_diff   = wrap_src - dmlr_pkg::PHASE_ONE;
      pos_wrapped = {1'b0, wrap_diff[dmlr_pkg::STEP_W-1:0]};
   end

   // ---------------------------------------------------------------------------------
   // Sequencer: next state.
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dmlr_pkg::ST_IDLE: begin
            if (req_valid && frame_done) begin
               state_in = dmlr_pkg::ST_DIV;
            end
         end
         dmlr_pkg::ST_DIV: begin
            if (div_done) begin
               if (have_prev_ff && pos_in_frame) begin
                  state_in = dmlr_pkg::ST_MUL;
               end else begin
                  state_in = dmlr_pkg::ST_IDLE;
               end
            end
         end
         dmlr_pkg::ST_MUL: begin
            state_in = dmlr_pkg::ST_OUT;
         end
         dmlr_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = run_last ? dmlr_pkg::ST_IDLE : dmlr_pkg::ST_MUL;
            end
         end
         default: begin
            state_in = dmlr_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Sequencer: control outputs.
   // ---------------------------------------------------------------------------------
   always_comb begin
      ctrl      = '0;
      req_stall = 1'b1;
      case (state_ff)
         dmlr_pkg::ST_IDLE: begin
            req_stall      = 1'b0;
            ctrl.accept    = req_valid;
            ctrl.div_start = req_valid && frame_done;
         end
         dmlr_pkg::ST_MUL: begin
            ctrl.mul_issue = 1'b1;
         end
         dmlr_pkg::ST_OUT: begin
            ctrl.emit = out_free;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Stream state update.
   // ---------------------------------------------------------------------------------
   always_comb begin
      chan_idx_in  = chan_idx_ff;
      chan_sum_in  = chan_sum_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      have_prev_in = have_prev_ff;
      pos_in       = pos_ff;
      run_cnt_in   = run_cnt_ff;

      if (ctrl.accept) begin
         if (req_stream_start) begin
            prev_in      = '0;
            have_prev_in = 1'b0;
            pos_in       = '0;
         end
         if (frame_done) begin
            chan_idx_in = '0;
            chan_sum_in = '0;
         end else begin
            chan_idx_in = idx_inc[IDX_W-1:0];
            chan_sum_in = new_sum;
         end
      end

      if (state_ff == dmlr_pkg::ST_DIV && div_done) begin
         cur_in     = div_mono;
         run_cnt_in = '0;
         if (!have_prev_ff) begin
            // First frame of a stream is only stored.
            prev_in      = div_mono;
            have_prev_in = 1'b1;
         end else if (!pos_in_frame) begin
            // Step larger than one frame: nothing falls between these two frames.
            prev_in = div_mono;
            pos_in  = pos_wrapped;
         end
      end

      if (ctrl.emit) begin
         run_cnt_in = run_cnt_ff + dmlr_pkg::RUN_CNT_W'(1);
         if (run_last) begin
            prev_in = cur_ff;
            pos_in  = pos_wrapped;
         end else begin
            pos_in  = pos_next;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Output register: holds one result beat while the block carries on.
   // ---------------------------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;
      if (ctrl.emit) begin
         out_valid_in  = 1'b1;
         out_sample_in = interp_out;
         out_last_in   = run_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= dmlr_pkg::CHANNEL_COUNT_RESET;
         step_ff       <= dmlr_pkg::STEP_RESET;
         state_ff      <= dmlr_pkg::ST_IDLE;
         chan_idx_ff   <= '0;
         chan_sum_ff   <= '0;
         prev_ff       <= '0;
         have_prev_ff  <= 1'b0;
         pos_ff        <= '0;
         run_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         chan_count_ff <= chan_count_in;
         step_ff       <= step_in;
         state_ff      <= state_in;
         chan_idx_ff   <= chan_idx_in;
         chan_sum_ff   <= chan_sum_in;
         prev_ff       <= prev_in;
         have_prev_ff  <= have_prev_in;
         pos_ff        <= pos_in;
         run_cnt_ff    <= run_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
   end

   // ---------------------------------------------------------------------------------
   // Arithmetic units.
   // ---------------------------------------------------------------------------------
   dmlr_avg_div #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_avg_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (new_sum),
      .divisor  (n_eff),
      .done     (div_done),
      .quotient (div_mono)
   );

   dmlr_interp u_interp (
      .clock     (clock),
      .issue     (ctrl.mul_issue),
      .prev_mono (prev_ff),
      .cur_mono  (cur_ff),
      .frac      (pos_ff[dmlr_pkg::FRAC_W-1:0]),
      .result    (interp_out)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_sample_out  = out_sample_ff;
   assign rsp_last_in_run = out_last_ff;

endmodule

[sv/dmlr_avg_div.sv]
// Iterative restoring divider that averages a frame's channel sum to mono.
// Rounds to nearest, ties away from zero. Depends on dmlr_pkg.

module dmlr_avg_div #(
   parameter int unsigned MAX_CHANNELS = dmlr_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [dmlr_pkg::SAMPLE_W+$clog2(MAX_CHANNELS)-1:0] dividend,
   input  logic        [$clog2(MAX_CHANNELS+1)-1:0] divisor,
   output logic                                   done,
   output logic signed [dmlr_pkg::SAMPLE_W-1:0]   quotient
);

   localparam int unsigned SUM_W = dmlr_pkg::SAMPLE_W + $clog2(MAX_CHANNELS);
   localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int unsigned ITER_W = $clog2(SUM_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  work_ff, work_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;

   logic [SUM_W-1:0]  mag;
   logic [CNT_W:0]    rem_shift;
   logic [CNT_W:0]    rem_diff;
   logic              fits;

   always_comb begin
      mag       = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_shift = {rem_ff, work_ff[SUM_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      fits      = rem_shift >= {1'b0, div_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      neg_in  = neg_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;

      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         neg_in  = dividend[SUM_W-1];
         work_in = mag + SUM_W'(divisor >> 1);
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // One quotient bit per cycle, shifted in behind the dividend bits.
         rem_in  = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
         work_in = {work_ff[SUM_W-2:0], fits};
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   // The magnitude never exceeds 32768, so the low bits carry the whole result.
   assign done     = done_ff;
   assign quotient = neg_ff ? -work_ff[dmlr_pkg::SAMPLE_W-1:0]
                            : work_ff[dmlr_pkg::SAMPLE_W-1:0];

endmodule

[sv/dmlr_interp.sv]
// Linear interpolation unit: registered multiply, then round, add and saturate.
// Depends on dmlr_pkg.

module dmlr_interp (
   input  logic                                  clock,
   input  logic                                  issue,
   input  logic signed [dmlr_pkg::SAMPLE_W-1:0]  prev_mono,
   input  logic signed [dmlr_pkg::SAMPLE_W-1:0]  cur_mono,
   input  logic        [dmlr_pkg::FRAC_W-1:0]    frac,
   output logic signed [dmlr_pkg::SAMPLE_W-1:0]  result
);

   localparam int unsigned DIFF_W = dmlr_pkg::SAMPLE_W + 1;
   localparam int unsigned PROD_W = DIFF_W + dmlr_pkg::FRAC_W + 1;
   localparam int unsigned ADJ_W  = PROD_W - dmlr_pkg::FRAC_W;
   localparam int unsigned TOT_W  = ADJ_W + 1;

   logic signed [DIFF_W-1:0]            diff;
   logic signed [PROD_W-1:0]            prod_ff, prod_in;
   logic signed [dmlr_pkg::SAMPLE_W-1:0] base_ff, base_in;
   logic signed [PROD_W-1:0]            rounded;
   logic signed [ADJ_W-1:0]             adjust;
   logic signed [TOT_W-1:0]             total;

   always_comb begin
      diff    = {cur_mono[dmlr_pkg::SAMPLE_W-1], cur_mono}
              - {prev_mono[dmlr_pkg::SAMPLE_W-1], prev_mono};
      prod_in = issue ? diff * $signed({1'b0, frac}) : prod_ff;
      base_in = issue ? prev_mono : base_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= base_in;
   end

   // Half an LSB added, then a floor shift: ties go toward plus infinity.
   always_comb begin
      rounded = prod_ff + PROD_W'(32768);
      adjust  = rounded[PROD_W-1:dmlr_pkg::FRAC_W];
      total   = TOT_W'(base_ff) + TOT_W'(adjust);
      if (total > TOT_W'(32767)) begin
         result = 16'sh7FFF;
      end else if (total < -TOT_W'(32768)) begin
         result = 16'sh8000;
      end else begin
         result = total[dmlr_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

[sv/dmlr_checker.sv]
// Port-level checks for the downmix linear resampler, bound to its top level.
// Depends on dmlr_pkg and downmix_linear_resampler_core.

module dmlr_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [dmlr_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input logic                                   rsp_last_in_run
);

   // A stalled result beat is held unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out)
                                 && $stable(rsp_last_in_run))
      else $error("result beat changed while stalled");

   // The block only goes busy because it has just taken a frame-closing beat.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("input stall raised without an accepted beat");

   // New results appear only while a frame is being worked on.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat appeared while the block was idle");

   // Result beats are never presented while reset has just been released.
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat valid straight after reset");

endmodule

bind downmix_linear_resampler_core dmlr_checker u_dmlr_checker (.*);

[sim/tb_downmix_linear_resampler_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for downmix_linear_resampler_core: directed table then random segments.
// Depends on dmlr_pkg and the RTL of the block; needs no files or arguments.

module tb_downmix_linear_resampler_core;

   // A beat that closes a frame keeps the block busy while it is averaged and
   // interpolated, so the settle time before a register write leaves a generous margin.
   localparam int SETTLE_CYCLES = 64;
   // Longest stretch with no beat moving on any channel before the run is abandoned.
   // The slowest correct stretch is a settle wait plus one busy frame and a long stall.
   localparam int QUIET_LIMIT   = 3000;
   localparam int FRAME_MAX     = dmlr_pkg::MAX_CHANNELS_DEF;
   localparam int PHASE_UNIT    = 65536;
   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_BEATS = 28;
   localparam int PRINT_CAP     = 40;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum {ROW_CSR, ROW_BEAT} row_kind_type;

   // One expected result beat.
   typedef struct {
      logic signed [dmlr_pkg::SAMPLE_W-1:0] pcm;
      logic                                 run_end;
   } mono_beat_type;

   // One row of the directed table. A row with known set carries a single result that
   // is typed in here rather than taken from the predictor.
   typedef struct {
      row_kind_type                         kind;
      logic [dmlr_pkg::CSR_IDX_W-1:0]       csr_idx;
      logic [dmlr_pkg::CSR_DATA_W-1:0]      csr_val;
      logic signed [dmlr_pkg::SAMPLE_W-1:0] pcm;
      bit                                   fresh;
      bit                                   known;
      logic signed [dmlr_pkg::SAMPLE_W-1:0] known_pcm;
   } stim_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [dmlr_pkg::SAMPLE_W-1:0] req_sample_in = '0;
   logic                                 req_stream_start = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [dmlr_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic                                 rsp_last_in_run;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [dmlr_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [dmlr_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   // Mirror of the block's registers and stream state, as the predictor sees them.
   logic [dmlr_pkg::CNT_REG_W-1:0]       cfg_channels = dmlr_pkg::CHANNEL_COUNT_RESET;
   logic [dmlr_pkg::STEP_W-1:0]          cfg_step = dmlr_pkg::STEP_RESET;
   logic [3:0]                           frame_fill = '0;
   logic signed [18:0]                   frame_sum = '0;
   logic signed [dmlr_pkg::SAMPLE_W-1:0] held_mono = '0;
   bit                                   have_held = 1'b0;
   logic [dmlr_pkg::STEP_W-1:0]          phase_pos = '0;

   mono_beat_type                pending_mono[$];
   stim_row_type                 stim_rows[$];
   mono_beat_type                head;

   int                           sender_idle_pct = 0;
   int                           receiver_stall_pct = 0;
   int                           mismatch_count = 0;
   int                           beats_sent = 0;
   int                           results_checked = 0;
   int                           csr_writes = 0;
   int                           quiet_cycles = 0;

   downmix_linear_resampler_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_last_in_run  (rsp_last_in_run),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
   endtask

   // Takes one accepted channel sample into the stream state and queues every result
   // that it causes. Returns the number of results queued.
   function automatic int predict_mono_resample(
      input logic signed [dmlr_pkg::SAMPLE_W-1:0] pcm, input bit fresh);
      int          n;
      int unsigned stride;
      int unsigned pos;
      int          mag;
      int          cur;
      int          made;
      longint      acc;
      longint      q;
      // A start flag clears the stream state but keeps the registers.
      if (fresh) begin
         frame_fill = '0;
         frame_sum  = '0;
         held_mono  = '0;
         have_held  = 1'b0;
         phase_pos  = '0;
      end
      // A zero channel count acts as one; counts above the frame limit are clipped.
      n = int'(cfg_channels);
      if (n == 0) n = 1;
      if (n > FRAME_MAX) n = FRAME_MAX;
      // Steps below a quarter are raised to a quarter, which caps a frame at four results.
      stride = cfg_step;
      if (stride < int'(dmlr_pkg::MIN_STEP)) stride = dmlr_pkg::MIN_STEP;

      frame_sum  = frame_sum + pcm;
      frame_fill = frame_fill + 4'd1;
      if (int'(frame_fill) < n) return 0;

      // Average to mono, rounding to nearest with ties away from zero.
      mag = (frame_sum < 0) ? -int'(frame_sum) : int'(frame_sum);
      cur = (mag + n / 2) / n;
      if (frame_sum < 0) cur = -cur;
      frame_sum  = '0;
      frame_fill = '0;

      // The first frame of a stream is only held.
      if (!have_held) begin
         held_mono = dmlr_pkg::SAMPLE_W'(cur);
         have_held = 1'b1;
         return 0;
      end

      made = 0;
      pos  = phase_pos;
      while (pos < PHASE_UNIT && made < 4) begin
         acc = longint'(held_mono) * 65536
             + longint'(cur - int'(held_mono)) * longint'(pos & 32'hFFFF) + 32768;
         q = (acc >= 0) ? acc / 65536 : -((-acc + 65535) / 65536);
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         pending_mono.push_back('{pcm: dmlr_pkg::SAMPLE_W'(q), run_end: 1'b0});
         made++;
         pos = pos + stride;
      end
      if (made > 0) pending_mono[$].run_end = 1'b1;
      phase_pos = dmlr_pkg::STEP_W'(pos - PHASE_UNIT);
      held_mono = dmlr_pkg::SAMPLE_W'(cur);
      return made;
   endfunction

   function automatic void set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
         default:       begin sender_idle_pct = 32; receiver_stall_pct = 32; end
      endcase
   endfunction

   function automatic void add_csr(input logic [dmlr_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [dmlr_pkg::CSR_DATA_W-1:0] val);
      stim_rows.push_back('{kind: ROW_CSR, csr_idx: idx, csr_val: val, pcm: '0,
                            fresh: 1'b0, known: 1'b0, known_pcm: '0});
   endfunction

   function automatic void add_beat(input logic signed [dmlr_pkg::SAMPLE_W-1:0] pcm,
                                    input bit fresh, input bit known,
                                    input logic signed [dmlr_pkg::SAMPLE_W-1:0] out);
      stim_rows.push_back('{kind: ROW_BEAT, csr_idx: '0, csr_val: '0, pcm: pcm,
                            fresh: fresh, known: known, known_pcm: out});
   endfunction

   // Offers one sample beat, after a random idle stretch, and holds it until taken.
   task automatic send_beat(input logic signed [dmlr_pkg::SAMPLE_W-1:0] pcm,
                            input bit fresh, output int made);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_in    <= pcm;
      req_stream_start <= fresh;
      do @(posedge clock); while (req_stall);
      made = predict_mono_resample(pcm, fresh);
      beats_sent++;
   endtask

   // Drops the request, waits for every expected result and then for the block to
   // finish any frame that produced none, so that a register write lands while idle.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_mono.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [dmlr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dmlr_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == dmlr_pkg::CSR_CHANNEL_COUNT) cfg_channels = val[dmlr_pkg::CNT_REG_W-1:0];
      else cfg_step = val[dmlr_pkg::STEP_W-1:0];
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: random stall, then each taken beat is checked against the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (pending_mono.size() == 0) begin
            flag_mismatch($sformatf("result %0d with none expected", rsp_sample_out));
         end else begin
            head = pending_mono.pop_front();
            if (rsp_sample_out !== head.pcm)
               flag_mismatch($sformatf("sample_out %0d, expected %0d",
                                       rsp_sample_out, head.pcm));
            if (rsp_last_in_run !== head.run_end)
               flag_mismatch($sformatf("last_in_run %b, expected %b (sample %0d)",
                                       rsp_last_in_run, head.run_end, head.pcm));
         end
      end
   end

   // Watchdog: ends the run when no beat has moved on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: watchdog expired, %0d results still expected",
                  $time, pending_mono.size());
         $display("** downmix_linear_resampler_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                                   made;
      int                                   seg;
      int                                   k;
      logic [3:0]                           seg_channels;
      logic [dmlr_pkg::STEP_W-1:0]          seg_step;
      logic signed [dmlr_pkg::SAMPLE_W-1:0] pcm;
      bit                                   fresh;

      // Directed table. Registers start at one channel and a step of one.
      // First frame of a stream is only held; from then on each frame gives one result.
      add_beat(16'sd100, 1'b1, 1'b0, '0);
      add_beat(16'sd32767, 1'b0, 1'b1, 16'sd100);
      add_beat(-16'sd32768, 1'b0, 1'b1, 16'sd32767);
      add_beat(-16'sd32768, 1'b0, 1'b1, -16'sd32768);
      // A step of one half gives two results per frame.
      add_csr(dmlr_pkg::CSR_STEP_Q16, 24'd32768);
      add_beat(16'sd0, 1'b0, 1'b0, '0);
      // A zero step is raised to a quarter: four results per frame.
      add_csr(dmlr_pkg::CSR_STEP_Q16, 24'd0);
      add_beat(16'sd32767, 1'b0, 1'b0, '0);
      // Largest step: one result, which leaves the phase far past the next frame.
      add_csr(dmlr_pkg::CSR_STEP_Q16, 24'hFFFFFF);
      add_beat(-16'sd5, 1'b0, 1'b0, '0);
      // A step of one and a half, on a fresh stream, includes a frame with no result.
      add_csr(dmlr_pkg::CSR_STEP_Q16, 24'd98304);
      add_beat(16'sd7, 1'b1, 1'b0, '0);
      add_beat(-16'sd7, 1'b0, 1'b0, '0);
      add_beat(16'sd9, 1'b0, 1'b0, '0);
      add_beat(16'sd3, 1'b0, 1'b0, '0);
      // Two channels: averages that round away from zero on both signs.
      add_csr(dmlr_pkg::CSR_CHANNEL_COUNT, 24'd2);
      add_beat(-16'sd1, 1'b0, 1'b0, '0);
      add_beat(-16'sd2, 1'b0, 1'b0, '0);
      add_beat(16'sd5, 1'b0, 1'b0, '0);
      add_beat(16'sd6, 1'b0, 1'b0, '0);
      // Count lowered part way through a frame: the frame closes on the next beat.
      add_csr(dmlr_pkg::CSR_CHANNEL_COUNT, 24'd4);
      add_beat(16'sd1, 1'b0, 1'b0, '0);
      add_beat(16'sd2, 1'b0, 1'b0, '0);
      add_csr(dmlr_pkg::CSR_CHANNEL_COUNT, 24'd2);
      add_beat(16'sd3, 1'b0, 1'b0, '0);
      // A zero count acts as one channel.
      add_csr(dmlr_pkg::CSR_CHANNEL_COUNT, 24'd0);
      add_beat(16'sd1000, 1'b0, 1'b0, '0);
      // A count of fifteen is clipped to eight; the full-scale frame sum is reached.
      add_csr(dmlr_pkg::CSR_CHANNEL_COUNT, 24'hFFFFFF);
      for (k = 0; k < FRAME_MAX; k++) add_beat(-16'sd32768, 1'b0, 1'b0, '0);

      set_idle_mode(IDLE_NONE);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            settle_block();
            write_csr(stim_rows[i].csr_idx, stim_rows[i].csr_val);
         end else begin
            send_beat(stim_rows[i].pcm, stim_rows[i].fresh, made);
            // Rows with a typed-in result replace what the predictor queued for them.
            if (stim_rows[i].known) begin
               repeat (made) void'(pending_mono.pop_back());
               pending_mono.push_back('{pcm: stim_rows[i].known_pcm, run_end: 1'b1});
            end
         end
      end

      // Random segments. Each one settles the block, sets both registers, picks an idle
      // mode and plays a fresh stream: mostly whole frames, with the odd stray restart.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin seg_channels = 4'd1; seg_step = dmlr_pkg::MIN_STEP; end
            1: begin seg_channels = 4'd8; seg_step = 24'd65536; end
            2: begin seg_channels = 4'd2;
                     seg_step = dmlr_pkg::STEP_W'($urandom_range(0, 16383)); end
            3: begin seg_channels = 4'd0;
                     seg_step = dmlr_pkg::STEP_W'($urandom_range(16384, 120000)); end
            4: begin seg_channels = 4'd15;
                     seg_step = dmlr_pkg::STEP_W'($urandom_range(16384, 70000)); end
            5: begin seg_channels = 4'd3;
                     seg_step = dmlr_pkg::STEP_W'($urandom_range(20000, 200000)); end
            6: begin seg_channels = 4'd1; seg_step = 24'hFFFFFF; end
            default: begin seg_channels = 4'($urandom_range(1, 4));
                           seg_step = dmlr_pkg::STEP_W'($urandom_range(16384, 100000)); end
         endcase
         settle_block();
         write_csr(dmlr_pkg::CSR_CHANNEL_COUNT, {20'($urandom), seg_channels});
         write_csr(dmlr_pkg::CSR_STEP_Q16, seg_step);
         set_idle_mode(idle_mode_type'(seg % 4));
         for (k = 0; k < SEGMENT_BEATS; k++) begin
            case ($urandom_range(0, 7))
               0: pcm = -16'sd32768;
               1: pcm = 16'sd32767;
               default: pcm = dmlr_pkg::SAMPLE_W'($urandom);
            endcase
            fresh = (k == 0) || ($urandom_range(0, 47) == 0);
            send_beat(pcm, fresh, made);
         end
      end

      // Drain: every expected result, then the block's own latency.
      req_valid <= 1'b0;
      while (pending_mono.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d sample beats and %0d register writes over four idle patterns;",
               beats_sent, csr_writes);
      $display("%0d result beats were checked, %0d mismatches.",
               results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("** downmix_linear_resampler_core: PASSED **");
      end else begin
         $display("** downmix_linear_resampler_core: FAILED **");
      end
      $finish;
   end

endmodule
